/* design/ttsb_pkg.sv */
package ttsb_pkg;

    // Command codes carried in the cmd field
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Byte codes interpreted by the put command
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_FIRST = 8'd32;
    localparam logic [7:0] CH_LAST  = 8'd126;
    localparam logic [6:0] CH_SUBST = 7'd46;

    localparam int CELL_W = 7;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [5:0] read_col;
    } req_item_t;

    typedef struct packed {
        logic [6:0] cell_data;
        logic [5:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_STORE,
        ST_MARK,
        ST_RDWAIT,
        ST_DONE
    } state_t;

endpackage

/* design/text_terminal_screen_buffer_unit.sv */
// Character screen buffer for a text terminal.
// Request channel (req_valid/req_ready/req) takes one item per command:
// put a byte at the cursor, read one cell, or clear the screen and home the
// cursor. Response channel (rsp_valid/rsp_ready/rsp) returns exactly one item
// per request with the cell read (0 for other commands), the cursor after
// the command and a flag that is set when the screen scrolled.
// Control bytes, clear, the unused command and reads of empty or off-screen
// cells go from decode straight to the response; other reads pass a read
// wait state, and stored characters pass the store and mark states. The
// next request is taken in the cycle after the response is loaded.
// The cell store is a single-port RAM addressed by physical row. Rows are
// kept in a ring: a scroll only moves the top-row pointer and marks the new
// bottom row empty. A row that is marked empty is zeroed one cell at a time
// the first time a character or end marker lands in it.
// Reset (and the clear command) marks every row empty; there is no clearing
// pass. One request is worked at a time; req_ready is high in the idle
// state, and a finished response waits in the output register while the
// next request is accepted. If the receiver stalls, the block holds the
// next result until the output register frees up.
module text_terminal_screen_buffer_unit
    import ttsb_pkg::*;
#(
    parameter int SCREEN_COLS = 62,
    parameter int SCREEN_ROWS = 18
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int DEPTH = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW    = $clog2(DEPTH);
    // Widths that hold both the internal index and the port field
    localparam int CXW   = (CW > 6) ? CW : 6;
    localparam int RXW   = (RW > 5) ? RW : 5;

    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    req_item_t            item_reg, item_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [RW-1:0]        base_reg, base_next;
    logic [SCREEN_ROWS-1:0] row_ok_reg, row_ok_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CELL_W-1:0]    cell_reg, cell_next;
    logic                 scrolled_reg, scrolled_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_reg, rsp_next;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_addr;
    logic [CELL_W-1:0]    mem_wdata, mem_rdata;

    logic [RW:0]          cur_sum, rd_sum;
    logic [RW-1:0]        phys_cur, phys_rd;
    logic [RXW-1:0]       rd_row_ext;
    logic [CXW-1:0]       rd_col_ext, col_ext;
    logic [RXW-1:0]       row_ext;
    logic [RW-1:0]        rd_row;
    logic [CW-1:0]        rd_col;
    logic                 rd_in_range;
    logic                 at_bottom;
    logic [RW-1:0]        base_inc;
    logic                 last_col;
    logic [CELL_W-1:0]    put_char;
    logic                 rsp_free;

    // Map logical rows onto the ring of physical rows
    assign cur_sum  = {1'b0, row_reg} + {1'b0, base_reg};
    assign phys_cur = (cur_sum >= (RW + 1)'(SCREEN_ROWS))
                    ? RW'(cur_sum - (RW + 1)'(SCREEN_ROWS)) : cur_sum[RW-1:0];

    assign rd_row_ext  = RXW'(item_reg.read_row);
    assign rd_col_ext  = CXW'(item_reg.read_col);
    assign rd_row      = rd_row_ext[RW-1:0];
    assign rd_col      = rd_col_ext[CW-1:0];
    assign rd_in_range = (32'(item_reg.read_row) < SCREEN_ROWS)
                      && (32'(item_reg.read_col) < SCREEN_COLS);
    assign rd_sum      = {1'b0, rd_row} + {1'b0, base_reg};
    assign phys_rd     = (rd_sum >= (RW + 1)'(SCREEN_ROWS))
                       ? RW'(rd_sum - (RW + 1)'(SCREEN_ROWS)) : rd_sum[RW-1:0];

    assign at_bottom = (row_reg == RW'(SCREEN_ROWS - 1));
    assign base_inc  = (base_reg == RW'(SCREEN_ROWS - 1)) ? '0 : base_reg + 1'b1;
    assign last_col  = (col_reg == CW'(SCREEN_COLS - 1));

    // Substitute '.' for bytes outside the printable range
    assign put_char = ((item_reg.char_code < CH_FIRST) || (item_reg.char_code > CH_LAST))
                    ? CH_SUBST : item_reg.char_code[CELL_W-1:0];

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign col_ext = CXW'(col_reg);
    assign row_ext = RXW'(row_reg);

    ttsb_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                if (item_reg.cmd == CMD_PUT)
                begin
                    if ((item_reg.char_code != CH_CR) && (item_reg.char_code != CH_LF)
                        && (item_reg.char_code != CH_BS))
                    begin
                        state_next = row_ok_reg[phys_cur] ? ST_STORE : ST_SWEEP;
                    end
                end
                else if (item_reg.cmd == CMD_READ)
                begin
                    if (rd_in_range && row_ok_reg[phys_rd])
                    begin
                        state_next = ST_RDWAIT;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (cnt_reg == CW'(SCREEN_COLS - 1))
                begin
                    state_next = ret_reg;
                end
            end
            ST_STORE:
            begin
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                state_next = row_ok_reg[phys_cur] ? ST_DONE : ST_SWEEP;
            end
            ST_RDWAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and cursor updates
    always_comb
    begin
        item_next      = item_reg;
        ret_next       = ret_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        row_ok_next    = row_ok_reg;
        cnt_next       = cnt_reg;
        cell_next      = cell_reg;
        scrolled_next  = scrolled_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = AW'(phys_cur) * AW'(SCREEN_COLS) + AW'(col_reg);
        mem_wdata      = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                end
            end
            ST_DECODE:
            begin
                cell_next     = '0;
                scrolled_next = 1'b0;
                cnt_next      = '0;
                if (item_reg.cmd == CMD_PUT)
                begin
                    if (item_reg.char_code == CH_CR)
                    begin
                        col_next = '0;
                    end
                    else if (item_reg.char_code == CH_LF)
                    begin
                        col_next = '0;
                        if (at_bottom)
                        begin
                            // Scroll: old top row becomes the empty bottom row
                            row_ok_next[base_reg] = 1'b0;
                            base_next             = base_inc;
                            scrolled_next         = 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else if (item_reg.char_code == CH_BS)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                            // An empty row already reads as zero
                            mem_addr = AW'(phys_cur) * AW'(SCREEN_COLS)
                                     + AW'(col_reg - 1'b1);
                            mem_we   = row_ok_reg[phys_cur];
                        end
                    end
                    else
                    begin
                        ret_next = ST_STORE;
                    end
                end
                else if (item_reg.cmd == CMD_READ)
                begin
                    mem_addr = AW'(phys_rd) * AW'(SCREEN_COLS) + AW'(rd_col);
                    mem_re   = rd_in_range && row_ok_reg[phys_rd];
                end
                else if (item_reg.cmd == CMD_CLEAR)
                begin
                    row_ok_next = '0;
                    base_next   = '0;
                    col_next    = '0;
                    row_next    = '0;
                end
            end
            ST_SWEEP:
            begin
                // Zero the cursor row one cell a cycle, then mark it live
                mem_addr = AW'(phys_cur) * AW'(SCREEN_COLS) + AW'(cnt_reg);
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SCREEN_COLS - 1))
                begin
                    cnt_next              = '0;
                    row_ok_next[phys_cur] = 1'b1;
                end
            end
            ST_STORE:
            begin
                mem_we    = 1'b1;
                mem_wdata = put_char;
                if (last_col)
                begin
                    col_next = '0;
                    if (at_bottom)
                    begin
                        row_ok_next[base_reg] = 1'b0;
                        base_next             = base_inc;
                        scrolled_next         = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_MARK:
            begin
                // End marker; an empty row gets it from the sweep instead
                mem_we   = row_ok_reg[phys_cur];
                ret_next = ST_DONE;
            end
            ST_RDWAIT:
            begin
                cell_next = mem_rdata;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.cell_data  = cell_reg;
                    rsp_next.cursor_col = col_ext[5:0];
                    rsp_next.cursor_row = row_ext[4:0];
                    rsp_next.scrolled   = scrolled_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_DONE;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            row_ok_reg    <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            row_ok_reg    <= row_ok_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cell_reg     <= cell_next;
        scrolled_reg <= scrolled_next;
        rsp_reg      <= rsp_next;
    end

endmodule

/* design/ttsb_cell_ram.sv */
module ttsb_cell_ram
    import ttsb_pkg::*;
#(
    parameter int DEPTH = 1116,
    parameter int AW    = 11
)
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [AW-1:0]     addr,
    input  logic [CELL_W-1:0] wdata,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];

    // Single port: write or registered read at one address per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* verif/tb_text_terminal_screen_buffer_unit.sv */
import ttsb_pkg::*;

class screen_scoreboard #(int COLS = 62, int ROWS = 18);

    logic [6:0] cells [ROWS][COLS];
    int         cur_col;
    int         cur_row;
    rsp_item_t  pending_replies[$];
    int         mismatch_count;

    function new();
        wipe_screen();
        mismatch_count = 0;
    endfunction

    function void wipe_screen();
        foreach (cells[r, c])
            cells[r][c] = '0;
        cur_col = 0;
        cur_row = 0;
    endfunction

    function bit next_line();
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS)
            return 1'b0;
        cur_row = ROWS - 1;
        for (int r = 0; r < ROWS - 1; r++)
            cells[r] = cells[r + 1];
        for (int c = 0; c < COLS; c++)
            cells[ROWS - 1][c] = '0;
        return 1'b1;
    endfunction

    function bit store_byte(logic [7:0] code);
        logic [6:0] glyph;
        bit         did_scroll;
        did_scroll = 1'b0;
        if (code == CH_CR) begin
            cur_col = 0;
            return 1'b0;
        end
        if (code == CH_LF)
            return next_line();
        if (code == CH_BS) begin
            if (cur_col > 0) begin
                cur_col--;
                cells[cur_row][cur_col] = '0;
            end
            return 1'b0;
        end
        glyph = (code < CH_FIRST || code > CH_LAST) ? CH_SUBST : code[6:0];
        cells[cur_row][cur_col] = glyph;
        cur_col++;
        if (cur_col >= COLS)
            did_scroll = next_line();
        cells[cur_row][cur_col] = '0;
        return did_scroll;
    endfunction

    function rsp_item_t predict_terminal_step(req_item_t it);
        rsp_item_t exp_rsp;
        exp_rsp = '0;
        case (it.cmd)
            CMD_PUT:
                exp_rsp.scrolled = store_byte(it.char_code);
            CMD_READ:
                if (it.read_row < ROWS && it.read_col < COLS)
                    exp_rsp.cell_data = cells[it.read_row][it.read_col];
            CMD_CLEAR:
                wipe_screen();
            default: ;
        endcase
        exp_rsp.cursor_col = 6'(cur_col);
        exp_rsp.cursor_row = 5'(cur_row);
        return exp_rsp;
    endfunction

    function void note_request(req_item_t it);
        pending_replies.push_back(predict_terminal_step(it));
    endfunction

    function int pending();
        return pending_replies.size();
    endfunction

    function void flag(string what, int exp_val, int got_val);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, what, exp_val, got_val);
    endfunction

    function void check_response(rsp_item_t got);
        rsp_item_t exp_rsp;
        if (pending_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
        end
        exp_rsp = pending_replies.pop_front();
        if (got.cell_data !== exp_rsp.cell_data)
            flag("cell_data", exp_rsp.cell_data, got.cell_data);
        if (got.cursor_col !== exp_rsp.cursor_col)
            flag("cursor_col", exp_rsp.cursor_col, got.cursor_col);
        if (got.cursor_row !== exp_rsp.cursor_row)
            flag("cursor_row", exp_rsp.cursor_row, got.cursor_row);
        if (got.scrolled !== exp_rsp.scrolled)
            flag("scrolled", exp_rsp.scrolled, got.scrolled);
    endfunction

endclass

module tb_text_terminal_screen_buffer_unit;

    localparam int SCREEN_COLS = 62;
    localparam int SCREEN_ROWS = 18;
    // Unused command code; the block must leave everything alone
    localparam logic [1:0] CMD_SPARE = 2'd3;
    // Longest put: zero a fresh row, store, then zero the next row for the end marker
    localparam int TAIL_CYCLES = 2 * SCREEN_COLS + 16;
    // Cycles with no handshake on either channel before giving up
    localparam int HANG_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 500;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int line_feed_pct = 5;
    int quiet_cycles = 0;

    screen_scoreboard #(SCREEN_COLS, SCREEN_ROWS) sb;

    text_terminal_screen_buffer_unit #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: decide on the falling edge whether to take a response at the
    // next rising edge, so that stalls land on every phase of the work.
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted response against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("tb_text_terminal_screen_buffer_unit: FAIL");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item: idle at random on falling edges, then hold valid and
    // payload steady until the block takes the item at a rising edge.
    // Valid is only ever assigned once per falling edge, so back-to-back
    // items keep it high without a glitch.
    task automatic send_item(input req_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(it);
    endtask

    // Hold the request side idle until every predicted response has come.
    task automatic drain_replies();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic req_item_t make_item(logic [1:0] cmd, logic [7:0] code,
                                            logic [4:0] row, logic [5:0] col);
        req_item_t it;
        it.cmd       = cmd;
        it.char_code = code;
        it.read_row  = row;
        it.read_col  = col;
        return it;
    endfunction

    task automatic send_put(input logic [7:0] code);
        send_item(make_item(CMD_PUT, code, 5'($urandom), 6'($urandom)));
    endtask

    task automatic send_read(input logic [4:0] row, input logic [5:0] col);
        send_item(make_item(CMD_READ, 8'($urandom), row, col));
    endtask

    // Mostly text: printable runs broken by line feeds, carriage returns and
    // backspaces, with reads both around the cursor and anywhere on (or off)
    // the screen. Clears stay rare so the screen fills and scrolls.
    function automatic req_item_t random_item();
        req_item_t it;
        int        pick;
        int        probe_col;
        it   = make_item(CMD_PUT, 8'($urandom), 5'($urandom), 6'($urandom));
        pick = $urandom_range(999);
        if (pick < 3) begin
            it.cmd = CMD_CLEAR;
        end
        else if (pick < 20) begin
            it.cmd = CMD_SPARE;
        end
        else if (pick < 240) begin
            it.cmd = CMD_READ;
            case ($urandom_range(2))
                0: begin
                    // Look around the cursor: end marker and erased cells
                    probe_col   = sb.cur_col + $urandom_range(2) - 1;
                    it.read_row = 5'(sb.cur_row);
                    it.read_col = 6'(probe_col);
                end
                1: begin
                    it.read_row = 5'($urandom_range(SCREEN_ROWS - 1));
                    it.read_col = 6'($urandom_range(SCREEN_COLS - 1));
                end
                default: ;
            endcase
        end
        else if (pick < 240 + line_feed_pct * 10) begin
            it.char_code = CH_LF;
        end
        else if (pick < 270 + line_feed_pct * 10) begin
            it.char_code = CH_CR;
        end
        else if (pick < 320 + line_feed_pct * 10) begin
            it.char_code = CH_BS;
        end
        else if (pick < 360 + line_feed_pct * 10) begin
            // Any byte at all, so control and high codes get substituted
            it.char_code = 8'($urandom);
        end
        else begin
            it.char_code = 8'($urandom_range(CH_LAST, CH_FIRST));
        end
        return it;
    endfunction

    initial
    begin
        int idle_plan  [4];
        int stall_plan [4];

        idle_plan  = '{0, 85, 0, 33};
        stall_plan = '{0, 0, 85, 33};
        sb = new();

        // Reset once, then release it on a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: fresh screen, backspace at column zero, field extremes,
        // byte substitution, erase, line control, reads off the screen,
        // the spare command code and clear.
        send_read(5'd0, 6'd0);
        send_put(CH_BS);
        send_put(8'd65);
        send_put(CH_FIRST);
        send_put(CH_LAST);
        send_put(8'd127);
        send_put(8'd255);
        send_put(8'd0);
        send_put(8'd31);
        send_put(CH_BS);
        send_read(5'd0, 6'd0);
        send_read(5'd0, 6'd6);
        send_read(5'd0, 6'd7);
        send_put(CH_CR);
        send_put(8'd90);
        send_put(CH_LF);
        send_read(5'd0, 6'd1);
        send_read(5'(SCREEN_ROWS - 1), 6'(SCREEN_COLS - 1));
        send_read(5'(SCREEN_ROWS), 6'd0);
        send_read(5'd0, 6'(SCREEN_COLS));
        send_read(5'd31, 6'd63);
        send_item(make_item(CMD_SPARE, 8'hFF, 5'd31, 6'd63));
        send_item(make_item(CMD_CLEAR, 8'hFF, 5'd31, 6'd63));
        send_read(5'd0, 6'd0);
        drain_replies();

        // Random phases; pause the sender until all replies are in between
        // phases so idle gaps line up with an empty pipeline too.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Alternate long lines (wrap at the last column) with short
                // ones (many line feeds, hence scrolling).
                if (n % 64 == 0)
                    line_feed_pct = $urandom_range(1) ? 0 : 8;
                send_item(random_item());
            end
            drain_replies();
        end

        // Let any stray response show up before the verdict.
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("tb_text_terminal_screen_buffer_unit: PASS");
        else
            $display("tb_text_terminal_screen_buffer_unit: FAIL");
        $finish;
    end

endmodule
